FILE: src/oodq_pkg.sv
// ----------------------------------------------------------------------------
// oodq_pkg
// Shared types and constants for the occupancy on/off delay qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package oodq_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_W         = 4;
    localparam int TIME_W       = 32;
    localparam int DELAY_W      = 16;
    localparam int COOL_W       = 16;
    localparam int MS_PER_S     = 1000;
    // 65535 s * 1000 fits in 26 bits
    localparam int COOL_MS_W    = 26;

    typedef enum logic
    {
        KIND_SAMPLE = 1'b0,
        KIND_TIMING = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t               kind;
        logic [CH_W-1:0]     channel;
        logic                occupied;
        logic [TIME_W-1:0]   now_ms;
        logic [DELAY_W-1:0]  delay_ms;
        logic [COOL_W-1:0]   cooldown_s;
    } sample_t;

    typedef struct packed
    {
        logic [CH_W-1:0] out_channel;
        logic            report_valid;
        logic            report_value;
    } result_t;

    // pipeline control passed from the top level to the stages
    typedef struct packed
    {
        logic load;     // input register takes a new request
        logic advance;  // input register hands its request on
    } pipe_ctrl_t;

endpackage

`default_nettype wire

FILE: src/oodq_in_stage.sv
// ----------------------------------------------------------------------------
// oodq_in_stage
// Input register: holds one accepted request and its valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module oodq_in_stage
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  oodq_pkg::pipe_ctrl_t ctrl,
    input  oodq_pkg::sample_t    sample,
    output logic                 item_valid,
    output oodq_pkg::sample_t    item
);
    import oodq_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    sample_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.load)
        begin
            valid_next = 1'b1;
        end
        else if (ctrl.advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            item_reg <= sample;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: src/oodq_qualify.sv
// ----------------------------------------------------------------------------
// oodq_qualify
// Per-channel state and the single-pass edge / timeout evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module oodq_qualify
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  commit,
    input  oodq_pkg::sample_t    item,
    output oodq_pkg::result_t    res
);
    import oodq_pkg::*;

    logic                 raw_reg      [NUM_CHANNELS];
    logic                 pend_on_reg  [NUM_CHANNELS];
    logic                 pend_off_reg [NUM_CHANNELS];
    logic [TIME_W-1:0]    on_start_reg [NUM_CHANNELS];
    logic [TIME_W-1:0]    off_start_reg[NUM_CHANNELS];
    logic [DELAY_W-1:0]   delay_reg    [NUM_CHANNELS];
    logic [COOL_MS_W-1:0] cool_ms_reg  [NUM_CHANNELS];

    logic [IDX_W-1:0]     idx;
    logic                 in_range;
    logic                 is_sample;
    logic                 lvl;
    logic                 pend_on_next;
    logic                 pend_off_next;
    logic [TIME_W-1:0]    on_start_next;
    logic [TIME_W-1:0]    off_start_next;
    logic [TIME_W-1:0]    on_elapsed;
    logic [TIME_W-1:0]    off_elapsed;
    logic                 fire_on;
    logic                 fire_off;
    logic [COOL_MS_W-1:0] cool_ms_next;

    assign idx       = IDX_W'(item.channel);
    assign in_range  = (32'(item.channel) < NUM_CHANNELS);
    assign is_sample = (item.kind == KIND_SAMPLE);
    assign lvl       = item.occupied;

    // seconds to ms at write time keeps the multiply off the sample path
    assign cool_ms_next = COOL_MS_W'(item.cooldown_s) * COOL_MS_W'(MS_PER_S);

    always_comb
    begin
        pend_on_next   = pend_on_reg[idx];
        pend_off_next  = pend_off_reg[idx];
        on_start_next  = on_start_reg[idx];
        off_start_next = off_start_reg[idx];

        // edge handling; a repeated edge keeps its older stamp
        if (lvl != raw_reg[idx])
        begin
            if (!lvl)
            begin
                pend_on_next = 1'b0;
                if (!pend_off_reg[idx])
                begin
                    pend_off_next  = 1'b1;
                    off_start_next = item.now_ms;
                end
            end
            else
            begin
                pend_off_next = 1'b0;
                if (!pend_on_reg[idx])
                begin
                    pend_on_next  = 1'b1;
                    on_start_next = item.now_ms;
                end
            end
        end

        on_elapsed  = item.now_ms - on_start_next;
        off_elapsed = item.now_ms - off_start_next;

        fire_on  = pend_on_next && lvl &&
                   ((delay_reg[idx] == '0) ||
                    (on_elapsed >= TIME_W'(delay_reg[idx])));
        fire_off = pend_off_next && !lvl &&
                   ((cool_ms_reg[idx] == '0) ||
                    (off_elapsed >= TIME_W'(cool_ms_reg[idx])));

        if (fire_on)
        begin
            pend_on_next = 1'b0;
        end
        if (fire_off)
        begin
            pend_off_next = 1'b0;
        end

        res.out_channel  = item.channel;
        res.report_valid = in_range && is_sample && (fire_on || fire_off);
        res.report_value = in_range && is_sample && fire_on;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                raw_reg[i]       <= 1'b0;
                pend_on_reg[i]   <= 1'b0;
                pend_off_reg[i]  <= 1'b0;
                on_start_reg[i]  <= '0;
                off_start_reg[i] <= '0;
                delay_reg[i]     <= '0;
                cool_ms_reg[i]   <= '0;
            end
        end
        else if (commit && in_range)
        begin
            if (is_sample)
            begin
                raw_reg[idx]       <= lvl;
                pend_on_reg[idx]   <= pend_on_next;
                pend_off_reg[idx]  <= pend_off_next;
                on_start_reg[idx]  <= on_start_next;
                off_start_reg[idx] <= off_start_next;
            end
            else
            begin
                delay_reg[idx]   <= item.delay_ms;
                cool_ms_reg[idx] <= cool_ms_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/oodq_out_stage.sv
// ----------------------------------------------------------------------------
// oodq_out_stage
// Result register and the stage-advance decision.
// ----------------------------------------------------------------------------
`default_nettype none

module oodq_out_stage
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    input  oodq_pkg::result_t    res,
    input  wire                  result_stall,
    output logic                 advance,
    output logic                 result_valid,
    output oodq_pkg::result_t    result
);
    import oodq_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;
    logic    free;

    // slot is free when empty or being taken this cycle
    assign free    = !valid_reg || !result_stall;
    assign advance = item_valid && free;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: src/occupancy_on_off_delay_qualifier_top.sv
// ----------------------------------------------------------------------------
// occupancy_on_off_delay_qualifier_top
// Per-channel occupancy qualifier with on-delay and off-cooldown.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (sample_valid / sample_stall / sample): either an
//    occupancy sample (channel, raw level, time in ms) or a timing write
//    (channel, on-delay in ms, off-cooldown in s).
//  - Result channel (result_valid / result_stall / result): exactly one
//    result per request, in order, echoing the channel, with report_valid
//    set when a qualified occupied/clear report fires.
//  - Path: a request passes through the input register, then the result
//    register, before result_valid rises.
//    Throughput: one request per cycle while result_stall holds no result,
//    set by the single read-modify-write of the per-channel state flops.
//  - Back-to-back requests on the same channel are safe: state is written
//    at the edge the request leaves the input register.
//  - Reset clears all channel state (levels, pending flags, stamps, delays
//    and cooldowns) and both pipeline valids at once; no clearing pass.
//  - When result_stall is high with a result held, the pipeline freezes;
//    sample_stall rises only if the input register is also occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_on_off_delay_qualifier_top
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                sample_valid,
    output logic               sample_stall,
    input  oodq_pkg::sample_t  sample,
    output logic               result_valid,
    input  wire                result_stall,
    output oodq_pkg::result_t  result
);
    import oodq_pkg::*;

    pipe_ctrl_t ctrl;
    logic       item_valid;
    sample_t    item;
    result_t    res;
    logic       advance;

    // input register can take a request when empty or when it moves on
    assign sample_stall = item_valid && !advance;
    assign ctrl.load    = sample_valid && !sample_stall;
    assign ctrl.advance = advance;

    oodq_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sample     (sample),
        .item_valid (item_valid),
        .item       (item)
    );

    // state commits exactly when the request moves to the result register
    oodq_qualify u_qual
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .item   (item),
        .res    (res)
    );

    oodq_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .res          (res),
        .result_stall (result_stall),
        .advance      (advance),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: src/oodq_checker.sv
// ----------------------------------------------------------------------------
// oodq_checker
// Port-level checks for the occupancy qualifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module oodq_checker
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                sample_valid,
    input  wire                sample_stall,
    input  oodq_pkg::sample_t  sample,
    input  wire                result_valid,
    input  wire                result_stall,
    input  oodq_pkg::result_t  result
);
    import oodq_pkg::*;

    // held result must not change while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // a stalled request is held unchanged by the sender
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> sample_valid && $stable(sample))
        else $error("stalled request changed");

    // an occupied report only exists alongside report_valid
    a_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.report_value |-> result.report_valid)
        else $error("report_value without report_valid");

    // with the result slot empty the pipeline always moves
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
        else $error("request stalled with empty result slot");

    // nothing comes out straight after reset
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid after reset");

endmodule

bind occupancy_on_off_delay_qualifier_top oodq_checker u_oodq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
